// ===== src/cbts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CAN bit timing search block.
// Used by cbts_div, cbts_search and can_bit_timing_search_top; no dependencies.
package cbts_pkg;

    localparam int CLK_W  = 27;
    localparam int RATE_W = 20;
    localparam int PROD_W = 14;
    localparam int STEP_W = 10;

    localparam logic [CLK_W-1:0] CLK_RESET = 27'd48000000;

    // last values of the search counters: div 15, quanta-1 31, segs-3 14
    localparam logic [3:0] DIV_LAST   = 4'd15;
    localparam logic [4:0] QUANTA_LAST = 5'd31;
    localparam logic [3:0] SEGS_LAST  = 4'd14;
    localparam logic [2:0] SJW_LIMIT  = 3'd3;

    // word index of the clock rate register
    localparam logic REG_CLK_HZ = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  prescaler;
        logic [14:0] timing_word;
    } srch_res_t;

endpackage

// ===== src/cbts_div.sv =====
`timescale 1ns / 1ps
// Restoring divider: clock rate over bit rate, one quotient bit per cycle.
// Depends on cbts_pkg.
module cbts_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cbts_pkg::CLK_W-1:0]  dividend,
    input  logic [cbts_pkg::RATE_W-1:0] divisor,
    output logic                        done,
    output logic [cbts_pkg::CLK_W-1:0]  quotient
);
    import cbts_pkg::*;

    localparam int CNT_W = $clog2(CLK_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [RATE_W-1:0]   dsr_reg, dsr_next;
    logic [CLK_W-1:0]    quo_reg, quo_next;
    logic [RATE_W:0]     shifted;
    logic [RATE_W:0]     diff;
    logic                fits;

    assign shifted = {rem_reg, quo_reg[CLK_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
            quo_next = {quo_reg[CLK_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/cbts_search.sv =====
`timescale 1ns / 1ps
// Search sequencer: walks prescaler, quanta and segment total, one compare per cycle.
// The running product is advanced by adding the step, not multiplied. Depends on cbts_pkg.
module cbts_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cbts_pkg::CLK_W-1:0] cpb,
    output logic                       done,
    output cbts_pkg::srch_res_t        res
);
    import cbts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [3:0]          d_reg, d_next;
    logic [4:0]          q_reg, q_next;
    logic [3:0]          s_reg, s_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CLK_W-1:0]    cpb_reg, cpb_next;
    srch_res_t           res_reg, res_next;
    logic                match;
    logic                last;
    logic [2:0]          seg1;
    logic [2:0]          seg2;
    logic [1:0]          sjw;

    assign match = cpb_reg == {{(CLK_W-PROD_W){1'b0}}, prod_reg};
    assign last  = (d_reg == DIV_LAST) && (q_reg == QUANTA_LAST) && (s_reg == SEGS_LAST);
    assign seg1  = s_reg[3:1];
    assign seg2  = s_reg[2:0] - seg1;
    assign sjw   = (seg1 > SJW_LIMIT) ? SJW_LIMIT[1:0] : seg1[1:0];

    always_comb
    begin
        logic [STEP_W-1:0] step_new;
        step_new  = '0;
        busy_next = busy_reg;
        done_next = 1'b0;
        d_next    = d_reg;
        q_next    = q_reg;
        s_next    = s_reg;
        step_next = step_reg;
        prod_next = prod_reg;
        cpb_next  = cpb_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            d_next    = '0;
            q_next    = '0;
            s_next    = '0;
            step_next = STEP_W'(1);
            prod_next = PROD_W'(3);
            cpb_next  = cpb;
        end
        else if (busy_reg)
        begin
            if (match)
            begin
                busy_next            = 1'b0;
                done_next            = 1'b1;
                res_next.found       = 1'b1;
                res_next.prescaler   = d_reg;
                res_next.timing_word = {seg2, 1'b0, seg1, sjw, 1'b0, q_reg};
            end
            else if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = '0;
            end
            else if (s_reg != SEGS_LAST)
            begin
                s_next    = s_reg + 1'b1;
                prod_next = prod_reg + PROD_W'(step_reg);
            end
            else
            begin
                // segment total wraps: restart product at 3 * step
                s_next = '0;
                if (q_reg != QUANTA_LAST)
                begin
                    q_next   = q_reg + 1'b1;
                    step_new = step_reg + STEP_W'(d_reg) + STEP_W'(1);
                end
                else
                begin
                    q_next   = '0;
                    d_next   = d_reg + 1'b1;
                    step_new = STEP_W'(d_reg) + STEP_W'(2);
                end
                step_next = step_new;
                prod_next = PROD_W'({step_new, 1'b0}) + PROD_W'(step_new);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        q_reg    <= q_next;
        s_reg    <= s_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        cpb_reg  <= cpb_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== src/can_bit_timing_search_top.sv =====
`timescale 1ns / 1ps
// CAN bit timing search: block top level with register port and output register.
// Depends on cbts_pkg, cbts_div and cbts_search.
//
// Usage: write the peripheral clock rate (Hz) at byte address 0 over the APB-style
// port; it resets to 48000000 and reads back. Present a bit rate word with in_valid;
// it is taken at a clock edge where in_valid is high and in_stall is low. Each word
// yields one result word (found, prescaler, timing_word) on the output channel,
// taken where out_valid is high and out_stall is low.
// Sequence: the taken word loads the divider, which runs a restoring division; its done
// starts the search, which makes one compare per candidate (prescaler 0..15, quanta
// 1..32, segment total 3..17) and stops at the first match; the registered search done
// moves the block to its hold state, which loads the output register once it is free.
// in_stall is high for the whole computation; one word is in flight at a time, and the
// next word can be taken the cycle after the result is loaded.
// A bit rate of zero or a clock rate of zero gives found=0 with zero fields.
// While the receiver stalls, the result waits in the output register; the next
// input word is still taken, but its result is held inside until the register frees.
// Reset clears the sequencer and the output valid and restores the clock rate.
module can_bit_timing_search_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [19:0] bit_rate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [3:0]  prescaler,
    output logic [14:0] timing_word
);
    import cbts_pkg::*;

    state_t              state_reg, state_next;
    logic [CLK_W-1:0]    clk_hz_reg;
    logic                out_valid_reg;
    srch_res_t           out_res_reg;
    logic                div_start;
    logic                div_done;
    logic [CLK_W-1:0]    cpb;
    logic                srch_start;
    logic                srch_done;
    srch_res_t           srch_res;
    logic                slot_free;
    logic                out_load;
    logic                accept;
    logic                reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2] == REG_CLK_HZ;
    assign prdata    = reg_sel ? {{(32-CLK_W){1'b0}}, clk_hz_reg} : '0;
    assign slot_free = !out_valid_reg || !out_stall;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clk_hz_reg <= CLK_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            clk_hz_reg <= pwdata[CLK_W-1:0];
    end

    cbts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clk_hz_reg),
        .divisor  (bit_rate),
        .done     (div_done),
        .quotient (cpb)
    );

    cbts_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_start),
        .cpb   (cpb),
        .done  (srch_done),
        .res   (srch_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_SEARCH;
            ST_SEARCH: if (srch_done) state_next = ST_HOLD;
            ST_HOLD:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        div_start  = 1'b0;
        srch_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                div_start = in_valid;
            end
            ST_DIV:    srch_start = div_done;
            ST_SEARCH: ;
            ST_HOLD:   out_load = slot_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the word while stalled
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_res_reg <= srch_res;
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_res_reg.found;
    assign prescaler   = out_res_reg.prescaler;
    assign timing_word = out_res_reg.timing_word;

`ifndef SYNTH
    a_accept_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DIV)
        else $error("accepted word did not start the divider");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_srch_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> state_reg == ST_SEARCH)
        else $error("search finished outside the search phase");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> prescaler == 4'd0 && timing_word == 15'd0)
        else $error("no-match word carries nonzero fields");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for can_bit_timing_search_top: directed and random bit rate words under
// several clock rate settings, checked against a timing predictor. Depends on cbts_pkg.
module tb_top;
    import cbts_pkg::*;

    localparam int          WATCHDOG_LIMIT = 80000;
    localparam int          HOLD_CYCLES    = 20000;
    localparam int          TAIL_CYCLES    = 8000;
    localparam int          SEGS_MIN       = 3;
    localparam logic [2:0]  CLK_ADDR       = {REG_CLK_HZ, 2'b00};
    localparam logic [2:0]  ADDR_UNUSED    = 3'd4;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [RATE_W-1:0] bit_rate;
    logic              out_valid;
    logic              out_stall;
    logic              found;
    logic [3:0]        prescaler;
    logic [14:0]       timing_word;

    logic [CLK_W-1:0]  periph_hz;
    srch_res_t         pending_timing[$];
    int                fail_count = 0;
    int                hold_req = 0;
    bit                idling = 1'b0;

    can_bit_timing_search_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bit_rate    (bit_rate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .prescaler   (prescaler),
        .timing_word (timing_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // First exact factorization of clocks per bit, prescaler outermost.
    function automatic srch_res_t timing_for_rate(input logic [CLK_W-1:0] hz,
                                                  input logic [RATE_W-1:0] rate);
        srch_res_t   res;
        int unsigned cpb;
        logic [3:0]  seg1;
        logic [2:0]  seg2;
        logic [1:0]  sjw;
        logic [5:0]  qfield;
        res = '0;
        if (rate == 0)
            return res;
        cpb = hz / rate;
        for (int d = 0; d <= int'(DIV_LAST); d++)
            for (int qm = 0; qm <= int'(QUANTA_LAST); qm++)
                for (int sm = 0; sm <= int'(SEGS_LAST); sm++)
                    if (cpb == (sm + SEGS_MIN) * (qm + 1) * (d + 1))
                    begin
                        seg1   = 4'(sm / 2);
                        seg2   = 3'(sm - sm / 2);
                        sjw    = (seg1 > SJW_LIMIT) ? SJW_LIMIT[1:0] : seg1[1:0];
                        qfield = 6'(qm);
                        res.found       = 1'b1;
                        res.prescaler   = 4'(d);
                        res.timing_word = {seg2, seg1, sjw, qfield};
                        return res;
                    end
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idling || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // Mostly rates that divide the clock into an exact product, the rest noise.
    function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] hz);
        int unsigned kind;
        int unsigned prod;
        int unsigned r;
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            prod = $urandom_range(1, 16) * $urandom_range(1, 32) * $urandom_range(3, 17);
            r = hz / prod;
            if (r != 0 && r < (1 << RATE_W))
                return r[RATE_W-1:0];
        end
        else if (kind < 85)
            return RATE_W'($urandom_range(1, 2000));
        r = $urandom();
        return r[RATE_W-1:0];
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (wr && addr == CLK_ADDR)
            periph_hz = data[CLK_W-1:0];
        if (!wr)
            check_field("prdata", {{(32 - CLK_W){1'b0}}, periph_hz}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_clock(input logic [2:0] addr, input logic [31:0] data);
        reg_access(1'b1, addr, data);
        reg_access(1'b0, CLK_ADDR, '0);
    endtask

    task automatic send_rate(input logic [RATE_W-1:0] rate);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        bit_rate <= rate;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_timing.push_back(timing_for_rate(periph_hz, rate));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_timing.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_value();
        reg_access(1'b0, CLK_ADDR, '0);
    endtask

    task automatic test_directed_rates();
        send_rate(20'd1000000);
        send_rate(20'd0);
        send_rate(20'hFFFFF);
        send_rate(20'd1);
        send_rate(20'd500000);
        send_rate(20'd125000);
        // prime clocks per bit above the segment range: no match
        send_rate(20'd905660);
        send_rate(20'd12345);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        // largest product: every field at its top value
        set_clock(CLK_ADDR, 32'd8704000);
        send_rate(20'd1000);
        wait_idle();
        // smallest product: found with all fields zero
        set_clock(CLK_ADDR, 32'd3000000);
        send_rate(20'd1000000);
        send_rate(20'd1);
        wait_idle();
    endtask

    task automatic test_clock_extremes();
        set_clock(CLK_ADDR, 32'd0);
        send_rate(20'd1);
        send_rate(20'hFFFFF);
        wait_idle();
        set_clock(CLK_ADDR, 32'd1);
        send_rate(20'd1);
        send_rate(20'd2);
        wait_idle();
        set_clock(CLK_ADDR, 32'd100000000);
        send_rate(20'd1000000);
        send_rate(20'hFFFFF);
        wait_idle();
        set_clock(CLK_ADDR, 32'hFFFFFFFF);
        send_rate(20'd1);
        send_rate(20'hFFFFF);
        wait_idle();
    endtask

    task automatic test_unused_address();
        set_clock(CLK_ADDR, 32'd48000000);
        set_clock(ADDR_UNUSED, $urandom());
        send_rate(20'd250000);
        wait_idle();
    endtask

    task automatic test_backpressure();
        idling = 1'b0;
        hold_req = HOLD_CYCLES;
        // keep offering words while results pile up behind the held receiver
        repeat (4) send_rate(pick_rate(periph_hz));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [31:0] clk_setting [5];
        clk_setting[0] = 32'd48000000;
        clk_setting[1] = 32'd100000000;
        clk_setting[2] = $urandom_range(1000000, 100000000);
        clk_setting[3] = $urandom();
        clk_setting[4] = 32'd16000000;
        foreach (clk_setting[i])
        begin
            idling = (i != 4);
            set_clock(CLK_ADDR, clk_setting[i]);
            repeat (16) send_rate(pick_rate(periph_hz));
            wait_idle();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        srch_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_timing.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result word: expected none, actual %0h/%0h/%0h",
                         $time, found, prescaler, timing_word);
            end
            else
            begin
                want = pending_timing.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("prescaler", 32'(want.prescaler), 32'(prescaler));
                check_field("timing_word", 32'(want.timing_word), 32'(timing_word));
            end
        end
    end

    // receiver: random stalls while idling is set, plus a long hold when a test asks for one
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
                out_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 99) < 20)
            begin
                n = stall_len();
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d words pending", $time,
                         pending_timing.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        bit_rate  = '0;
        periph_hz = CLK_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_value();
        test_directed_rates();
        test_field_extremes();
        test_clock_extremes();
        test_unused_address();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
